@@ rtl/assert_macros.svh @@
// Assertion macros for the vertex dedup indexer RTL.
// Depends on nothing; included by the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

@@ rtl/vdi_pkg.sv @@
// Package of the vertex dedup indexer: sizes, state and command types,
// and the float compare and canonicalization functions. Depends on nothing.
package vdi_pkg;
    localparam int MAX_VERTICES = 1024;
    localparam int BUCKETS      = 2048;
    localparam int EW = $clog2(MAX_VERTICES);
    localparam int BW = $clog2(BUCKETS);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int PW = $clog2(BUCKETS + 1);
    localparam int OW = 10;
    localparam int VW = 256;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLEAR, ST_HASH, ST_RDB, ST_WAITB, ST_RDE, ST_CMP, ST_WRITE, ST_OUT
    } state_t;

    typedef struct packed {
        logic load;      // latch input vertex, start hash
        logic hash_step; // one hash round
        logic clr_step;  // clear one bucket
        logic clr_init;
        logic rd_bucket;
        logic rd_entry;
        logic advance;   // next probe bucket
        logic store;     // write new vertex
        logic res_hit;
        logic res_new;
        logic res_full;
        logic cnt_clear;
    } cmd_t;

    typedef struct packed {
        logic hash_done;
        logic clr_done;
        logic bkt_valid;
        logic match;
        logic probe_done;
        logic count_full;
        logic start;
    } stat_t;

    function automatic logic is_nan(input logic [31:0] w);
        return w[30:0] > 31'h7F80_0000;
    endfunction

    function automatic logic feq(input logic [31:0] a, input logic [31:0] b);
        if (is_nan(a) || is_nan(b)) return 1'b0;
        return (a == b) || ((a[30:0] | b[30:0]) == 31'd0);
    endfunction

    function automatic logic [31:0] canon(input logic [31:0] w);
        return (w[30:0] == 31'd0) ? 32'd0 : w;
    endfunction
endpackage

@@ rtl/vdi_ram.sv @@
// Generic single-port-write, one-read RAM with registered read data.
// Depends on nothing.
module vdi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/vdi_ctrl.sv @@
// Controller state machine of the vertex dedup indexer.
// Depends on vdi_pkg.
module vdi_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    input  vdi_pkg::stat_t stat,
    output vdi_pkg::cmd_t  cmd
);
    import vdi_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_HASH;
                end
            end
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    // A clear started by start_mesh goes on to probe its vertex.
                    if (stat.start)
                    begin
                        state_next = ST_RDB;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (stat.hash_done)
                begin
                    if (stat.start)
                    begin
                        cmd.clr_init  = 1'b1;
                        cmd.cnt_clear = 1'b1;
                        state_next    = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_RDB;
                    end
                end
            end
            ST_RDB:
            begin
                cmd.rd_bucket = 1'b1;
                state_next    = ST_WAITB;
            end
            ST_WAITB:
            begin
                if (stat.probe_done)
                begin
                    cmd.res_full = 1'b1;
                    state_next   = ST_OUT;
                end
                else if (!stat.bkt_valid)
                begin
                    if (stat.count_full)
                    begin
                        cmd.res_full = 1'b1;
                        state_next   = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_WRITE;
                    end
                end
                else
                begin
                    cmd.rd_entry = 1'b1;
                    state_next   = ST_RDE;
                end
            end
            ST_RDE:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (stat.match)
                begin
                    cmd.res_hit = 1'b1;
                    state_next  = ST_OUT;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_RDB;
                end
            end
            ST_WRITE:
            begin
                cmd.store   = 1'b1;
                cmd.res_new = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

@@ rtl/vdi_datapath.sv @@
// Datapath of the vertex dedup indexer: hash unit, bucket valid and entry
// memories, vertex store, probe counter and result registers. Depends on vdi_pkg, vdi_ram.
module vdi_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  vdi_pkg::cmd_t          cmd,
    output vdi_pkg::stat_t         stat,
    input  logic                   start_mesh,
    input  logic [vdi_pkg::VW-1:0] vtx,
    output logic [vdi_pkg::OW-1:0] vtx_index,
    output logic                   is_new,
    output logic                   table_full
);
    import vdi_pkg::*;

    logic [VW-1:0] vtx_reg;
    logic          start_reg;
    logic [31:0]   h_reg, h_next;
    logic [2:0]    hcnt_reg;
    logic          hdone_reg;
    logic [BW-1:0] b_reg;
    logic [PW-1:0] probes_reg;
    logic [BW-1:0] clr_reg;
    logic          clr_last_reg;
    logic [CW-1:0] count_reg;
    logic [31:0]   prod;
    logic [31:0]   mixed;
    logic          vld_rd;
    logic [EW-1:0] ent_rd;
    logic [VW-1:0] st_rd;
    logic          vld_we;
    logic [BW-1:0] vld_wa;
    logic          match;

    assign mixed  = h_reg ^ canon(vtx_reg[hcnt_reg*32 +: 32]);
    assign prod   = mixed * 32'h9E37_79B1;
    assign h_next = prod ^ (prod >> 15);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hcnt_reg     <= '0;
            hdone_reg    <= 1'b0;
            clr_reg      <= '0;
            clr_last_reg <= 1'b0;
            count_reg    <= '0;
            probes_reg   <= '0;
            start_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                hcnt_reg  <= '0;
                hdone_reg <= 1'b0;
                start_reg <= start_mesh;
            end
            else if (cmd.hash_step && !hdone_reg)
            begin
                hcnt_reg  <= hcnt_reg + 3'd1;
                hdone_reg <= (hcnt_reg == 3'd7);
            end
            if (cmd.clr_init)
            begin
                clr_reg      <= '0;
                clr_last_reg <= 1'b0;
            end
            else if (cmd.clr_step)
            begin
                clr_reg      <= clr_reg + 1'b1;
                clr_last_reg <= (clr_reg == BW'(BUCKETS - 2));
            end
            if (cmd.cnt_clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.store)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.load)
            begin
                probes_reg <= '0;
            end
            else if (cmd.advance)
            begin
                probes_reg <= probes_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            vtx_reg <= vtx;
            h_reg   <= 32'h811C_9DC5;
        end
        else if (cmd.hash_step && !hdone_reg)
        begin
            h_reg <= h_next;
        end
        if (cmd.hash_step && hdone_reg)
        begin
            b_reg <= h_reg[BW-1:0];
        end
        else if (cmd.advance)
        begin
            b_reg <= b_reg + 1'b1;
        end
        if (cmd.res_hit)
        begin
            vtx_index  <= OW'(ent_rd);
            is_new     <= 1'b0;
            table_full <= 1'b0;
        end
        else if (cmd.res_new)
        begin
            vtx_index  <= OW'(count_reg);
            is_new     <= 1'b1;
            table_full <= 1'b0;
        end
        else if (cmd.res_full)
        begin
            vtx_index  <= '0;
            is_new     <= 1'b0;
            table_full <= 1'b1;
        end
    end

    // Clearing sweep writes zeros; a store marks its bucket valid.
    assign vld_we = cmd.clr_step || cmd.store;
    assign vld_wa = cmd.clr_step ? clr_reg : b_reg;

    vdi_ram #(.WIDTH(1), .DEPTH(BUCKETS)) u_valid (
        .clk(clk), .we(vld_we), .waddr(vld_wa), .wdata(cmd.store),
        .raddr(b_reg), .rdata(vld_rd)
    );

    vdi_ram #(.WIDTH(EW), .DEPTH(BUCKETS)) u_entry (
        .clk(clk), .we(cmd.store), .waddr(b_reg), .wdata(count_reg[EW-1:0]),
        .raddr(b_reg), .rdata(ent_rd)
    );

    vdi_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_store (
        .clk(clk), .we(cmd.store), .waddr(count_reg[EW-1:0]), .wdata(vtx_reg),
        .raddr(ent_rd), .rdata(st_rd)
    );

    always_comb
    begin
        match = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            match = match & feq(st_rd[i*32 +: 32], vtx_reg[i*32 +: 32]);
        end
    end

    assign stat.hash_done  = hdone_reg;
    assign stat.clr_done   = clr_last_reg;
    assign stat.bkt_valid  = vld_rd;
    assign stat.match      = match;
    assign stat.probe_done = (probes_reg == PW'(BUCKETS));
    assign stat.count_full = (count_reg == CW'(MAX_VERTICES));
    assign stat.start      = start_reg;
endmodule

@@ rtl/vertex_dedup_indexer_core.sv @@
// Top level of the vertex dedup indexer: controller plus datapath.
// Depends on vdi_pkg, vdi_ctrl, vdi_datapath, assert_macros.svh.
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | start_mesh, pos_*, norm_*, tex_*
//   out     | output    | out_valid / out_stall| vtx_index, is_new, table_full
// One vertex at a time: an accept state, the hash state (one multiply per
// component), then RDB, WAITB, RDE, CMP per occupied bucket probed over the
// registered bucket and store memories, RDB, WAITB for the empty bucket that
// ends a miss, plus a write state for a new vertex and an output state.
// Reset and start_mesh run a bucket clearing pass over all BUCKETS (2048) buckets
// with the input stalled. The result waits in its register while out_stall is high.
`include "assert_macros.svh"
module vertex_dedup_indexer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        start_mesh,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    input  logic [31:0] norm_x,
    input  logic [31:0] norm_y,
    input  logic [31:0] norm_z,
    input  logic [31:0] tex_u,
    input  logic [31:0] tex_v,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [9:0]  vtx_index,
    output logic        is_new,
    output logic        table_full
);
    import vdi_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    vdi_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
    );

    vdi_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .start_mesh(start_mesh),
        .vtx({tex_v, tex_u, norm_z, norm_y, norm_x, pos_z, pos_y, pos_x}),
        .vtx_index(vtx_index), .is_new(is_new), .table_full(table_full)
    );

    `ASSERT_IMPLY(a_no_accept_busy, clk, rst_n, out_valid, in_stall)
    `ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && out_stall, out_valid && $stable(vtx_index))
    `ASSERT_IMPLY(a_new_not_full, clk, rst_n, out_valid, !(is_new && table_full))
endmodule
